// File: hdl/stip_pkg.sv
package stip_pkg;

  // Fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned VALUE_W = 64;

  // Default accumulator width
  localparam int unsigned VALUE_BITS_DEF = 64;

  // Control from the parse core to the result register
  typedef struct packed {
    logic load;   // string closed, take the result
    logic minus;  // negate on output
  } stip_res_ctrl_t;

endpackage

// File: hdl/stip_parse_core.sv
module stip_parse_core #(
  parameter int unsigned VALUE_BITS = stip_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [stip_pkg::CHAR_W-1:0]   char_i,
  input  logic                          last_i,
  input  logic [stip_pkg::RADIX_W-1:0]  radix_i,
  output stip_pkg::stip_res_ctrl_t      res_o,
  output logic [VALUE_BITS-1:0]         mag_o
);
  import stip_pkg::*;

  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] PH_AFTER_SIGN = 3'd1;
  localparam logic [2:0] PH_AFTER_ZERO = 3'd2;
  localparam logic [2:0] PH_DIGITS     = 3'd3;
  localparam logic [2:0] PH_DONE       = 3'd4;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;

  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;
  localparam logic [RADIX_W-1:0] NO_DIGIT  = 5'd16;

  logic [2:0]            phase_q, phase_d;
  logic                  minus_q, minus_d;
  logic [RADIX_W-1:0]    active_q, active_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  logic [RADIX_W-1:0]    rad_w, rad_first, dig_rad;
  logic                  minus_w, prefixable, take_dig;
  logic [VALUE_BITS-1:0] acc_w, mac_w;
  logic [RADIX_W-1:0]    digit;

  // ASCII digit value, NO_DIGIT when not a hex digit
  always_comb begin
    digit = NO_DIGIT;
    if (char_i >= CH_0 && char_i <= CH_9) begin
      digit = RADIX_W'(char_i - CH_0);
    end else if (char_i >= CH_LO_A && char_i <= CH_LO_F) begin
      digit = RADIX_W'(char_i - CH_LO_A) + RADIX_DEC;
    end else if (char_i >= CH_UP_A && char_i <= CH_UP_F) begin
      digit = RADIX_W'(char_i - CH_UP_A) + RADIX_DEC;
    end
  end

  // first character of a string sees fresh state
  assign rad_w      = (phase_q == PH_START) ? radix_i : active_q;
  assign minus_w    = (phase_q == PH_START) ? 1'b0    : minus_q;
  assign acc_w      = (phase_q == PH_START) ? '0      : acc_q;
  assign prefixable = (rad_w == '0) || (rad_w == RADIX_HEX);
  assign rad_first  = (rad_w == '0) ? RADIX_DEC : rad_w;

  always_comb begin
    phase_d  = phase_q;
    minus_d  = minus_w;
    active_d = rad_w;
    take_dig = 1'b0;
    dig_rad  = rad_w;
    case (phase_q)
      PH_START, PH_AFTER_SIGN: begin
        if (phase_q == PH_START && (char_i == CH_PLUS || char_i == CH_MINUS)) begin
          minus_d = (char_i == CH_MINUS);
          phase_d = PH_AFTER_SIGN;
        end else begin
          active_d = rad_first;
          if (char_i == CH_0 && prefixable) begin
            phase_d = PH_AFTER_ZERO;
          end else begin
            take_dig = 1'b1;
            dig_rad  = rad_first;
          end
        end
      end
      PH_AFTER_ZERO: begin
        if (char_i == CH_LO_X || char_i == CH_UP_X) begin
          active_d = RADIX_HEX;
          phase_d  = PH_DIGITS;
        end else begin
          take_dig = 1'b1;
        end
      end
      PH_DIGITS: begin
        take_dig = 1'b1;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
    if (take_dig) begin
      phase_d = (digit >= NO_DIGIT || digit >= dig_rad) ? PH_DONE : PH_DIGITS;
    end
  end

  // one narrow multiply-add per character, wraps at VALUE_BITS
  assign mac_w = acc_w * VALUE_BITS'(dig_rad) + VALUE_BITS'(digit);
  assign acc_d = (take_dig && phase_d == PH_DIGITS) ? mac_w : acc_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      minus_q  <= 1'b0;
      active_q <= '0;
      acc_q    <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q  <= PH_START;
        minus_q  <= 1'b0;
        active_q <= '0;
        acc_q    <= '0;
      end else begin
        phase_q  <= phase_d;
        minus_q  <= minus_d;
        active_q <= active_d;
        acc_q    <= acc_d;
      end
    end
  end

  assign res_o.load  = step_i && last_i;
  assign res_o.minus = minus_d;
  assign mag_o       = acc_d;

endmodule

// File: hdl/stip_out_stage.sv
module stip_out_stage #(
  parameter int unsigned VALUE_BITS = stip_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stip_pkg::stip_res_ctrl_t            res_i,
  input  logic [VALUE_BITS-1:0]               mag_i,
  output logic                                free_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [stip_pkg::VALUE_W-1:0] parsed_value_o
);
  import stip_pkg::*;

  logic                         valid_q;
  logic                         minus_q;
  logic [VALUE_BITS-1:0]        mag_q;
  logic signed [VALUE_BITS-1:0] val_s;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      minus_q <= res_i.minus;
      mag_q   <= mag_i;
    end
  end

  // negate and sign-extend to the port width
  assign val_s          = minus_q ? $signed(~mag_q + 1'b1) : $signed(mag_q);
  assign parsed_value_o = VALUE_W'(val_s);
  assign out_valid_o    = valid_q;

endmodule

// File: hdl/string_to_integer_parser.sv
// The item marked last waits in the input register until the result register is free,
// then moves into it; the result is valid from that load on.
// Throughput: one character item per cycle unless a closing item waits for the
// full one-entry result register; set by the single accumulator-by-base multiply-add.
// Reset (rst_ni, asynchronous, active low): radix back to 0, parser back to
// waiting for a sign or first character, no item held, no result pending.
module string_to_integer_parser #(
  parameter int unsigned VALUE_BITS = stip_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: radix register
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stip_pkg::RADIX_W-1:0]        radix_i,
  // character items in
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [stip_pkg::CHAR_W-1:0]         char_code_i,
  input  logic                                end_of_string_i,
  // parsed value out
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [stip_pkg::VALUE_W-1:0] parsed_value_o
);
  import stip_pkg::*;

  logic [RADIX_W-1:0] radix_q;

  // input register: one character item
  logic              s1_valid_q;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_last_q;

  logic                  out_free;
  logic                  s1_step;
  stip_res_ctrl_t        res_ctrl;
  logic [VALUE_BITS-1:0] res_mag;

  // the register is always writable; it is only sampled on a string's first item
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
    end else if (cfg_valid_i) begin
      radix_q <= radix_i;
    end
  end

  // a held item moves on unless it closes a string and the result register is full and not being taken
  assign s1_step    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_code_i;
      s1_last_q <= end_of_string_i;
    end
  end

  stip_parse_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_step),
    .char_i  (s1_char_q),
    .last_i  (s1_last_q),
    .radix_i (radix_q),
    .res_o   (res_ctrl),
    .mag_o   (res_mag)
  );

  stip_out_stage #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res_ctrl),
    .mag_i          (res_mag),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_o (parsed_value_o)
  );

`ifndef ASSERT_OFF
  // closing an item always leaves a result waiting
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_step && s1_last_q |=> out_valid_o)
    else $error("closing item left no result");

  // a closing item never enters a full, stalled result register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctrl.load |-> out_free)
    else $error("result register overwritten");

  // a held closing item blocks new input while the result is stalled
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while closing item stalled");

  // a stalled result keeps its value
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(parsed_value_o))
    else $error("stalled result changed");
`endif

endmodule

// File: verif/tb_string_to_integer_parser.sv
module tb_string_to_integer_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import stip_pkg::*;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_F = "f";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_F  = "F";
  localparam logic [7:0] CH_LOW_X = "x";
  localparam logic [7:0] CH_UP_X  = "X";

  localparam int unsigned RADIX_AUTO = 0;
  localparam int unsigned RADIX_DEC  = 10;
  localparam int unsigned RADIX_HEX  = 16;

  // Margin allowed for the result after the closing item
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned NUM_PHASES   = 10;

  typedef enum logic [2:0] {
    SCAN_IDLE,       // waiting for sign or first character
    SCAN_SIGNED,     // sign taken
    SCAN_LEAD_ZERO,  // leading zero seen, prefix may follow
    SCAN_NUMBER,     // inside the digits
    SCAN_STOPPED     // no digit below the base seen, rest is ignored
  } scan_phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [RADIX_W-1:0]         radix_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [CHAR_W-1:0]          char_code_i = '0;
  logic                       end_of_string_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [VALUE_W-1:0]  parsed_value_o;

  string_to_integer_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .radix_i        (radix_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_o (parsed_value_o)
  );

  always #1 clk_i = ~clk_i;

  // Stimulus and scoreboard storage
  char_item_t                char_queue[$];
  logic signed [VALUE_W-1:0] parsed_due[$];
  int unsigned               items_queued = 0;
  int unsigned               mismatches = 0;
  int unsigned               idle_pct = 0;   // chance (%) of starting an idle burst
  int unsigned               gap_left = 0;
  int unsigned               stall_left = 0;
  logic                      in_fire = 1'b0; // item taken at the last rising edge

  // Shadow of the parser: register plus per-string state
  logic [RADIX_W-1:0]        radix_reg = '0;
  scan_phase_e               scan_phase = SCAN_IDLE;
  logic                      minus_q = 1'b0;
  int unsigned               base_q = 0;
  logic [VALUE_W-1:0]        acc_q = '0;

  // A character that is no digit below the base ends the number
  task automatic take_digit(input logic [7:0] c);
    int unsigned d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      d = c - CH_LOW_A + 10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + 10;
    end else begin
      d = 16;
    end
    if (d >= 16 || d >= base_q) begin
      scan_phase = SCAN_STOPPED;
    end else begin
      acc_q      = acc_q * VALUE_W'(base_q) + VALUE_W'(d);
      scan_phase = SCAN_NUMBER;
    end
  endtask

  // First character after an optional sign: auto base falls to decimal,
  // a zero may open a hex prefix for auto and base 16 only
  task automatic take_first(input logic [7:0] c);
    bit prefixable;
    prefixable = (base_q == RADIX_AUTO) || (base_q == RADIX_HEX);
    if (base_q == RADIX_AUTO) base_q = RADIX_DEC;
    if (c == CH_ZERO && prefixable) begin
      scan_phase = SCAN_LEAD_ZERO;
    end else begin
      take_digit(c);
    end
  endtask

  task automatic step_parser(input logic [7:0] c, input logic last,
                             output bit emit, output logic signed [VALUE_W-1:0] val);
    emit = 1'b0;
    val  = '0;
    case (scan_phase)
      SCAN_IDLE: begin
        // radix is sampled here, so later writes only hit the next string
        base_q  = radix_reg;
        minus_q = 1'b0;
        acc_q   = '0;
        if (c == CH_PLUS || c == CH_MINUS) begin
          minus_q    = (c == CH_MINUS);
          scan_phase = SCAN_SIGNED;
        end else begin
          take_first(c);
        end
      end
      SCAN_SIGNED: take_first(c);
      SCAN_LEAD_ZERO: begin
        if (c == CH_LOW_X || c == CH_UP_X) begin
          base_q     = RADIX_HEX;
          scan_phase = SCAN_NUMBER;
        end else begin
          take_digit(c);
        end
      end
      SCAN_NUMBER: take_digit(c);
      default: scan_phase = SCAN_STOPPED;
    endcase
    if (last) begin
      emit       = 1'b1;
      val        = minus_q ? -acc_q : acc_q;
      scan_phase = SCAN_IDLE;
      minus_q    = 1'b0;
      base_q     = 0;
      acc_q      = '0;
    end
  endtask

  // Sender: holds an item until taken, otherwise pops the next or idles
  always @(negedge clk_i) begin : drive_chars
    char_item_t item;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (char_queue.size() > 0 && $urandom_range(99) < idle_pct) begin
        gap_left   = $urandom_range(16, 0);
        in_valid_i <= 1'b0;
      end else if (char_queue.size() > 0) begin
        item            = char_queue.pop_front();
        in_valid_i      <= 1'b1;
        char_code_i     <= item.code;
        end_of_string_i <= item.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: back-pressure in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(99) < idle_pct) begin
        stall_left  = $urandom_range(16, 0);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: tracks register writes, predicts on every taken item and
  // checks every taken result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    bit                        emit;
    logic signed [VALUE_W-1:0] val;
    logic signed [VALUE_W-1:0] want;
    if (rst_ni) begin
      in_fire <= in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) radix_reg = radix_i;
      if (in_valid_i && in_ready_o) begin
        step_parser(char_code_i, end_of_string_i, emit, val);
        if (emit) parsed_due.push_back(val);
      end
      if (out_valid_o && out_ready_i) begin
        if (parsed_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected parsed_value %0d at %0t", parsed_value_o, $realtime);
        end else begin
          want = parsed_due.pop_front();
          if (parsed_value_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("parsed_value mismatch: expected %0d, got %0d at %0t",
                       want, parsed_value_o, $realtime);
          end
        end
      end
    end
  end

  task automatic push_char(input logic [7:0] c, input logic last);
    char_queue.push_back('{code: c, last: last});
    items_queued++;
  endtask

  task automatic send_str(input string s, input bit closes);
    for (int i = 0; i < s.len(); i++) push_char(s[i], closes && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1) ? CH_LOW_A : CH_UP_A) + 8'(d - 10);
  endfunction

  // Mostly well-formed numbers with random content, the rest noise
  task automatic gen_string(input int unsigned r);
    logic [7:0]  txt[$];
    int unsigned base;
    int unsigned n;
    bit          pre;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(8, 1);
      repeat (n) begin
        case ($urandom_range(5))
          0: txt.push_back(8'($urandom_range(255)));
          1: txt.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
          2: txt.push_back(CH_ZERO);
          3: txt.push_back($urandom_range(1) ? CH_LOW_X : CH_UP_X);
          default: txt.push_back(digit_char($urandom_range(15)));
        endcase
      end
    end else begin
      case ($urandom_range(3))
        0: txt.push_back(CH_PLUS);
        1: txt.push_back(CH_MINUS);
        default: ;
      endcase
      pre = (r == RADIX_AUTO || r == RADIX_HEX) && $urandom_range(1);
      if (pre) begin
        txt.push_back(CH_ZERO);
        txt.push_back($urandom_range(1) ? CH_LOW_X : CH_UP_X);
      end
      if (r == RADIX_AUTO) base = pre ? RADIX_HEX : RADIX_DEC;
      else if (r < 2 || r > RADIX_HEX) base = RADIX_HEX;
      else base = r;
      // occasional long runs to wrap the accumulator
      n = ($urandom_range(9) == 0) ? $urandom_range(26, 15) : $urandom_range(6, 1);
      repeat (n) txt.push_back(digit_char($urandom_range(base - 1)));
      if ($urandom_range(2) == 0) begin
        n = $urandom_range(4, 1);
        repeat (n) txt.push_back(8'($urandom_range(255)));
      end
    end
    foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
  endtask

  // Wait until every item is taken and every result seen, plus latency
  task automatic settle();
    while (char_queue.size() != 0 || in_valid_i || parsed_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input int unsigned r);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    radix_i     <= RADIX_W'(r);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned plan[NUM_PHASES] = '{1, 17, 31, 2, 10, 16, 0, 8, 0, 0};
    int unsigned r;
    int unsigned target;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings with the reset radix (auto)
    idle_pct = 20;
    send_str("-", 1);          // sign only gives zero
    send_str("7", 1);
    send_str("+0x1F", 1);      // auto base picks hex after 0x
    send_str("-0Xg", 1);       // prefix with no digits
    send_str("99z5", 1);       // tail after the stop is ignored
    push_char(8'hFF, 1'b1);
    push_char(8'h00, 1'b1);
    send_str("0", 1);
    // Radix written mid-string: the open string keeps decimal
    send_str("-12", 0);
    settle();
    write_radix(RADIX_HEX);
    send_str("3", 1);
    send_str("0xFf", 1);
    send_str("ab", 1);

    // Random phases, each under its own radix; some without idling,
    // the last one always without
    for (int k = 0; k < NUM_PHASES; k++) begin
      settle();
      r = (k == 7) ? $urandom_range(31) : plan[k];
      write_radix(r);
      idle_pct = (k == NUM_PHASES - 1 || k % 3 == 1) ? 0 : ((k % 3 == 0) ? 25 : 50);
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) gen_string(r);
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
